// File: hw/rtl/ufk_pkg.sv
// Shared types and constants for the union-find Kruskal linker.
`timescale 1ns / 1ps

package ufk_pkg;

  localparam int NODE_W         = 10;
  localparam int COUNT_W        = 11;
  localparam int WEIGHT_W       = 31;
  localparam int TOTAL_W        = 63;
  localparam int NODE_COUNT_DEF = 1024;

  typedef struct packed {
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] edge_weight;
  } ufk_in_t;

  typedef struct packed {
    logic                merged;
    logic [NODE_W-1:0]   root_out;
    logic [COUNT_W-1:0]  set_count;
    logic [TOTAL_W-1:0]  total_weight;
  } ufk_out_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic red_step;
    logic walk_iss;
    logic walk_step;
    logic walk_sel_b;
    logic sz_sel_a;
    logic sz_cap_a;
    logic commit;
  } ufk_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic root_found;
    logic out_free;
  } ufk_sts_t;

endpackage

// File: hw/rtl/ufk_modred.sv
// Reduction of a node index modulo the node count by reciprocal multiplication.
`timescale 1ns / 1ps

module ufk_modred #(
  parameter int NODE_COUNT = ufk_pkg::NODE_COUNT_DEF,
  parameter int NW         = $clog2(NODE_COUNT)
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     step,
  input  logic [ufk_pkg::NODE_W-1:0] raw,
  output logic [NW-1:0]            idx
);
  import ufk_pkg::*;

  localparam int SH    = NODE_W + $clog2(NODE_COUNT);
  localparam int PW    = 2 * NODE_W + 2;
  localparam int RECIP = ((1 << SH) + NODE_COUNT - 1) / NODE_COUNT;

  logic [NODE_W-1:0] raw_r;
  logic [NW-1:0]     rem_r;
  logic [PW-1:0]     prod;
  logic [NODE_W-1:0] quot;
  logic [NODE_W-1:0] rem;

  assign prod = PW'(raw_r) * PW'(RECIP);
  assign quot = NODE_W'(prod >> SH);
  assign rem  = raw_r - quot * NODE_W'(NODE_COUNT);
  assign idx  = rem_r;

  always_ff @(posedge clk) begin
    if (load) begin
      raw_r <= raw;
    end else if (step) begin
      rem_r <= NW'(rem);
    end
  end

endmodule

// File: hw/rtl/ufk_dpath.sv
// Datapath: parent and size memories, root walk, merge and output register.
`timescale 1ns / 1ps

module ufk_dpath #(
  parameter int NODE_COUNT = ufk_pkg::NODE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ufk_pkg::ufk_cmd_t cmd,
  output ufk_pkg::ufk_sts_t sts,
  input  ufk_pkg::ufk_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ufk_pkg::ufk_out_t out_data
);
  import ufk_pkg::*;

  localparam int NW   = $clog2(NODE_COUNT);
  localparam int CW   = $clog2(NODE_COUNT + 1);

  logic [NW-1:0]  par_mem [NODE_COUNT];
  logic [CW-1:0]  sz_mem  [NODE_COUNT];

  logic [NW-1:0]       clr_idx_r, clr_idx_nxt;
  logic [WEIGHT_W-1:0] w_r;
  logic [TOTAL_W-1:0]  wsum_r, wsum_nxt;
  logic [TOTAL_W-1:0]  wadd_r;
  logic [NW-1:0]       cur_r, ra_r, rb_r;
  logic [NW-1:0]       par_rd_r;
  logic [CW-1:0]       sz_rd_r, sa_r;
  logic                out_valid_r, out_valid_nxt;
  ufk_out_t            out_r;

  logic [NW-1:0]  idx_a, idx_b, start_node, par_raddr, par_waddr, par_wdata;
  logic [CW-1:0]  sz_waddr_w, sz_wdata;
  logic [NW-1:0]  sz_raddr;
  logic           par_we, sz_we;
  logic [TOTAL_W:0] wsum_ext;
  logic           diff, a_small;
  logic [NW-1:0]  keep, lose;
  logic [CW-1:0]  sum_sz, cnt;
  logic [31:0]    keep_ext, cnt_ext;
  logic           out_free;

  ufk_modred #(.NODE_COUNT(NODE_COUNT), .NW(NW)) u_red_a (
    .clk(clk), .load(cmd.load), .step(cmd.red_step), .raw(in_data.node_a), .idx(idx_a)
  );
  ufk_modred #(.NODE_COUNT(NODE_COUNT), .NW(NW)) u_red_b (
    .clk(clk), .load(cmd.load), .step(cmd.red_step), .raw(in_data.node_b), .idx(idx_b)
  );

  assign start_node = cmd.walk_sel_b ? idx_b : idx_a;
  assign par_raddr  = cmd.walk_step ? par_rd_r : start_node;
  assign sz_raddr   = cmd.sz_sel_a ? ra_r : rb_r;

  assign diff    = (ra_r != rb_r);
  assign a_small = (sa_r < sz_rd_r);
  assign keep    = a_small ? rb_r : ra_r;
  assign lose    = a_small ? ra_r : rb_r;
  assign sum_sz  = sa_r + sz_rd_r;
  assign cnt     = diff ? sum_sz : sa_r;
  assign keep_ext = 32'(keep);
  assign cnt_ext  = 32'(cnt);

  assign par_we    = cmd.clr_step || (cmd.commit && diff);
  assign par_waddr = cmd.clr_step ? clr_idx_r : lose;
  assign par_wdata = cmd.clr_step ? clr_idx_r : keep;
  assign sz_we     = par_we;
  assign sz_waddr_w = cmd.clr_step ? CW'(clr_idx_r) : CW'(keep);
  assign sz_wdata  = cmd.clr_step ? CW'(1) : sum_sz;

  assign wsum_ext = {1'b0, wsum_r} + (TOTAL_W+1)'(w_r);
  assign out_free = !out_valid_r || out_ready;

  assign sts.clr_last   = (clr_idx_r == NW'(NODE_COUNT - 1));
  assign sts.root_found = (par_rd_r == cur_r);
  assign sts.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rd_r <= par_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (sz_we) begin
      sz_mem[sz_waddr_w[NW-1:0]] <= sz_wdata;
    end
    sz_rd_r <= sz_mem[sz_raddr];
  end

  always_comb begin
    clr_idx_nxt   = cmd.clr_step ? clr_idx_r + NW'(1) : clr_idx_r;
    wsum_nxt      = (cmd.commit && diff) ? wadd_r : wsum_r;
    out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      wsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_idx_r   <= clr_idx_nxt;
      wsum_r      <= wsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wadd_r <= wsum_ext[TOTAL_W] ? '1 : wsum_ext[TOTAL_W-1:0];
    if (cmd.load) begin
      w_r <= in_data.edge_weight;
    end
    if (cmd.walk_iss) begin
      cur_r <= start_node;
    end else if (cmd.walk_step) begin
      cur_r <= par_rd_r;
    end
    if (cmd.walk_step && sts.root_found && !cmd.walk_sel_b) begin
      ra_r <= cur_r;
    end
    if (cmd.walk_step && sts.root_found && cmd.walk_sel_b) begin
      rb_r <= cur_r;
    end
    if (cmd.sz_cap_a) begin
      sa_r <= sz_rd_r;
    end
    if (cmd.commit) begin
      out_r.merged       <= diff;
      out_r.root_out     <= keep_ext[NODE_W-1:0];
      out_r.set_count    <= cnt_ext[COUNT_W-1:0];
      out_r.total_weight <= wsum_nxt;
    end
  end

endmodule

// File: hw/rtl/ufk_ctrl.sv
// Controller: sequences clearing, index reduction, root walks and merge.
`timescale 1ns / 1ps

module ufk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ufk_pkg::ufk_sts_t sts,
  output ufk_pkg::ufk_cmd_t cmd
);
  import ufk_pkg::*;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_REDUCE = 10'b0000000100,
    ST_A_ISS  = 10'b0000001000,
    ST_A_WALK = 10'b0000010000,
    ST_B_ISS  = 10'b0000100000,
    ST_B_WALK = 10'b0001000000,
    ST_SZ_A   = 10'b0010000000,
    ST_SZ_B   = 10'b0100000000,
    ST_DECIDE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
        state_nxt    = ST_A_ISS;
      end
      ST_A_ISS: begin
        cmd.walk_iss = 1'b1;
        state_nxt    = ST_A_WALK;
      end
      ST_A_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.root_found) state_nxt = ST_B_ISS;
      end
      ST_B_ISS: begin
        cmd.walk_iss   = 1'b1;
        cmd.walk_sel_b = 1'b1;
        state_nxt      = ST_B_WALK;
      end
      ST_B_WALK: begin
        cmd.walk_step  = 1'b1;
        cmd.walk_sel_b = 1'b1;
        if (sts.root_found) state_nxt = ST_SZ_A;
      end
      ST_SZ_A: begin
        cmd.sz_sel_a = 1'b1;
        state_nxt    = ST_SZ_B;
      end
      ST_SZ_B: begin
        cmd.sz_cap_a = 1'b1;
        state_nxt    = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/union_find_kruskal_linker_unit.sv
// Top level of the union-find Kruskal linker.
//
//   Channel | Direction | Contents
//   in_     | input     | node_a, node_b, edge_weight (one edge per beat)
//   out_    | output    | merged, root_out, set_count, total_weight
//
// A result is registered after its edge passes index reduction, a root walk for each
// endpoint that follows one link per cycle through the parent memory's single read
// port, and two size reads. The next beat can be accepted in the cycle after the result
// is registered, even while that result waits; a result still waiting when the next one
// is ready holds the engine. After reset a clearing pass over all NODE_COUNT entries
// initialises the memories; no beat is accepted meanwhile.
`timescale 1ns / 1ps

module union_find_kruskal_linker_unit #(
  parameter int NODE_COUNT = ufk_pkg::NODE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ufk_pkg::ufk_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ufk_pkg::ufk_out_t out_data
);
  import ufk_pkg::*;

  ufk_cmd_t cmd;
  ufk_sts_t sts;

  ufk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ufk_dpath #(.NODE_COUNT(NODE_COUNT)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
